@@ src/iasd_pkg.sv @@
// ----------------------------------------------------------------------------
// iasd_pkg
// shared types, constants and tables of the framed ima adpcm decoder
// ----------------------------------------------------------------------------
package iasd_pkg;

    localparam int STEP_MAX    = 88;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] SYNC_PATTERN_RESET    = 32'h434E_5953;
    localparam logic [15:0] BYTES_PER_BLOCK_RESET = 16'd1000;

    // configuration register indexes
    typedef enum logic {
        REG_SYNC_PATTERN    = 1'b0,
        REG_BYTES_PER_BLOCK = 1'b1
    } reg_index_t;

    // queue entry kinds
    typedef enum logic {
        ENTRY_LOAD  = 1'b0,
        ENTRY_AUDIO = 1'b1
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t        kind;
        logic [6:0]         step_pos;
        logic signed [15:0] pred;
        logic [7:0]         data;
    } queue_entry_t;

    localparam logic [14:0] STEP_SIZES [0:STEP_MAX] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
        15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
        15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
        15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
        15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
        15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
        15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        if (idx > 7'(STEP_MAX))
            step_size = STEP_SIZES[STEP_MAX];
        else
            step_size = STEP_SIZES[idx];
    endfunction

    function automatic logic signed [4:0] step_move(input logic [2:0] code);
        case (code)
            3'd4:    step_move = 5'sd2;
            3'd5:    step_move = 5'sd4;
            3'd6:    step_move = 5'sd6;
            3'd7:    step_move = 5'sd8;
            default: step_move = -5'sd1;
        endcase
    endfunction

endpackage

@@ src/iasd_byte_if.sv @@
// ----------------------------------------------------------------------------
// iasd_byte_if
// valid/ready channel carrying one received stream byte
// ----------------------------------------------------------------------------
interface iasd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ src/iasd_sample_if.sv @@
// ----------------------------------------------------------------------------
// iasd_sample_if
// valid/ready channel carrying one decoded pcm sample
// ----------------------------------------------------------------------------
interface iasd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

@@ src/iasd_queue.sv @@
// ----------------------------------------------------------------------------
// iasd_queue
// small fifo of decode requests between the framer and the decoder
// ----------------------------------------------------------------------------
module iasd_queue #(
    parameter int DEPTH = iasd_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  iasd_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output iasd_pkg::queue_entry_t head,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    iasd_pkg::queue_entry_t entries_reg [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ src/iasd_front.sv @@
// ----------------------------------------------------------------------------
// iasd_front
// byte framer: sync hunt, header capture, audio byte forwarding
// ----------------------------------------------------------------------------
module iasd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    iasd_byte_if.sink              in_ch,
    input  logic [31:0]            sync_pattern,
    input  logic [15:0]            bytes_per_block,
    output logic                   push,
    output iasd_pkg::queue_entry_t push_entry,
    input  logic                   q_full
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_HEADER = 3'b010,
        PH_AUDIO  = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  match_count_reg, match_count_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]  header_bytes_reg [3];

    logic        accept;
    logic        header_we;
    logic [7:0]  want;
    logic [15:0] step_raw;
    logic [6:0]  step_clamped;
    logic [15:0] remaining_dec;

    assign in_ch.ready   = !q_full;
    assign accept        = in_ch.valid && in_ch.ready;
    assign want          = sync_pattern[{match_count_reg, 3'b000} +: 8];
    assign step_raw      = {header_bytes_reg[1], header_bytes_reg[0]};
    assign remaining_dec = bytes_remaining_reg - 1'b1;

    // signed header step index clamped into the table range
    always_comb
    begin
        if (step_raw[15])
            step_clamped = '0;
        else if (step_raw > 16'(iasd_pkg::STEP_MAX))
            step_clamped = 7'(iasd_pkg::STEP_MAX);
        else
            step_clamped = step_raw[6:0];
    end

    always_comb
    begin
        phase_next           = phase_reg;
        match_count_next     = match_count_reg;
        header_count_next    = header_count_reg;
        bytes_remaining_next = bytes_remaining_reg;
        header_we            = 1'b0;
        push                 = 1'b0;
        push_entry.kind      = iasd_pkg::ENTRY_AUDIO;
        push_entry.step_pos  = step_clamped;
        push_entry.pred      = $signed({in_ch.data_byte, header_bytes_reg[2]});
        push_entry.data      = in_ch.data_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (header_count_reg != 2'd3)
                    begin
                        header_we         = 1'b1;
                        header_count_next = header_count_reg + 1'b1;
                    end
                    else
                    begin
                        push                 = 1'b1;
                        push_entry.kind      = iasd_pkg::ENTRY_LOAD;
                        header_count_next    = '0;
                        bytes_remaining_next = bytes_per_block;
                        phase_next           = PH_AUDIO;
                    end
                end
                PH_AUDIO:
                begin
                    push                 = 1'b1;
                    bytes_remaining_next = remaining_dec;
                    if (remaining_dec == '0)
                    begin
                        match_count_next = '0;
                        phase_next       = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (in_ch.data_byte != want)
                        match_count_next = '0;
                    else if (match_count_reg == 2'd3)
                    begin
                        match_count_next  = '0;
                        header_count_next = '0;
                        phase_next        = PH_HEADER;
                    end
                    else
                        match_count_next = match_count_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            match_count_reg     <= '0;
            header_count_reg    <= '0;
            bytes_remaining_reg <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            match_count_reg     <= match_count_next;
            header_count_reg    <= header_count_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (header_we)
            header_bytes_reg[header_count_reg] <= in_ch.data_byte;
    end

endmodule

@@ src/iasd_back.sv @@
// ----------------------------------------------------------------------------
// iasd_back
// nibble decoder: one adpcm nibble per unstalled cycle into a registered output
// ----------------------------------------------------------------------------
module iasd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iasd_pkg::queue_entry_t head,
    input  logic                   q_empty,
    output logic                   pop,
    iasd_sample_if.source          out_ch
);

    logic [6:0]         step_pos_reg, step_pos_next;
    logic signed [15:0] pred_reg, pred_next;
    logic               nib_sel_reg, nib_sel_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_sample_reg;
    logic               out_last_reg;

    logic               head_load;
    logic               emit;
    logic [3:0]         nibble;
    logic [14:0]        step;
    logic [16:0]        mag;
    logic signed [17:0] sum;
    logic signed [15:0] sample_sat;
    logic signed [8:0]  idx;
    logic [6:0]         idx_clamped;

    assign head_load = !q_empty && (head.kind == iasd_pkg::ENTRY_LOAD);
    assign emit      = !q_empty && (head.kind == iasd_pkg::ENTRY_AUDIO)
                       && (!out_valid_reg || out_ch.ready);
    assign pop       = head_load || (emit && nib_sel_reg);

    assign nibble = nib_sel_reg ? head.data[7:4] : head.data[3:0];
    assign step   = iasd_pkg::step_size(step_pos_reg);

    always_comb
    begin
        mag = 17'(step >> 3);
        if (nibble[0])
            mag = mag + 17'(step >> 2);
        if (nibble[1])
            mag = mag + 17'(step >> 1);
        if (nibble[2])
            mag = mag + 17'(step);
        if (nibble[3])
            sum = 18'(pred_reg) - $signed({1'b0, mag});
        else
            sum = 18'(pred_reg) + $signed({1'b0, mag});
        if (sum > 18'sd32767)
            sample_sat = 16'sh7FFF;
        else if (sum < -18'sd32768)
            sample_sat = 16'sh8000;
        else
            sample_sat = sum[15:0];
        idx = $signed({2'b00, step_pos_reg}) + 9'(iasd_pkg::step_move(nibble[2:0]));
        if (idx < 0)
            idx_clamped = '0;
        else if (idx > 9'sd88)
            idx_clamped = 7'(iasd_pkg::STEP_MAX);
        else
            idx_clamped = idx[6:0];
    end

    always_comb
    begin
        step_pos_next  = step_pos_reg;
        pred_next      = pred_reg;
        nib_sel_next   = nib_sel_reg;
        out_valid_next = out_valid_reg;
        if (out_ch.ready)
            out_valid_next = 1'b0;
        if (head_load)
        begin
            step_pos_next = head.step_pos;
            pred_next     = head.pred;
        end
        else if (emit)
        begin
            step_pos_next  = idx_clamped;
            pred_next      = sample_sat;
            nib_sel_next   = !nib_sel_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_pos_reg  <= '0;
            pred_reg      <= '0;
            nib_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_pos_reg  <= step_pos_next;
            pred_reg      <= pred_next;
            nib_sel_reg   <= nib_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sample_reg <= sample_sat;
            out_last_reg   <= nib_sel_reg;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.sample = out_sample_reg;
    assign out_ch.last   = out_last_reg;

    // step index never leaves the table
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_pos_reg <= 7'(iasd_pkg::STEP_MAX))
        else $error("step index out of range");

    // an audio request leaves the queue only after its high nibble
    a_pop_after_high: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head_load) |-> nib_sel_reg)
        else $error("audio request popped before its high nibble");

    // a decoded nibble always shows up at the output next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && (out_last_reg == $past(nib_sel_reg))))
        else $error("decoded sample not presented");

endmodule

@@ src/ima_adpcm_sync_decoder.sv @@
// ----------------------------------------------------------------------------
// ima_adpcm_sync_decoder
// sync-framed ima adpcm stream decoder, two pcm samples per audio byte
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                      handshake
//  -------   ---   -------------------------    ---------------------------
//  in_ch     in    data_byte[7:0]               valid/ready
//  out_ch    out   sample[15:0] s, last         valid/ready
//  wr_*      in    wr_index[0], wr_data[31:0]   wr_en, no back-pressure
//
//  hunt and header bytes are taken one per cycle unless the queue is full;
//  an audio byte is decoded as two nibbles, low first, one adpcm step per
//  cycle unless the output stalls (step table + add + saturate), and leaves
//  the queue with its high nibble; the framer keeps taking bytes while the
//  decoder works, until the request queue is full; a header load request
//  makes no sample; a stalled output holds one sample in the output register
//  reset clears framer, queue and decoder state, registers take defaults
//
module ima_adpcm_sync_decoder #(
    parameter int QUEUE_DEPTH = iasd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    iasd_byte_if.sink     in_ch,
    iasd_sample_if.source out_ch,
    input  logic          wr_en,
    input  logic          wr_index,
    input  logic [31:0]   wr_data
);

    // configuration registers, read by the framer
    logic [31:0] sync_pattern_reg;
    logic [15:0] bytes_per_block_reg;

    // request queue between framer and decoder
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    iasd_pkg::queue_entry_t q_push_entry;
    iasd_pkg::queue_entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg    <= iasd_pkg::SYNC_PATTERN_RESET;
            bytes_per_block_reg <= iasd_pkg::BYTES_PER_BLOCK_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                iasd_pkg::REG_SYNC_PATTERN:    sync_pattern_reg    <= wr_data;
                iasd_pkg::REG_BYTES_PER_BLOCK: bytes_per_block_reg <= wr_data[15:0];
                default:                       sync_pattern_reg    <= sync_pattern_reg;
            endcase
        end
    end

    // framer: sync hunt and header capture, forwards audio bytes
    iasd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .sync_pattern    (sync_pattern_reg),
        .bytes_per_block (bytes_per_block_reg),
        .push            (q_push),
        .push_entry      (q_push_entry),
        .q_full          (q_full)
    );

    iasd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // decoder: predictor and step index live here
    iasd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .out_ch  (out_ch)
    );

endmodule
